// ===== rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants for the byte square correlation block
// Widths of the running sums, the root and quotient engines, step counts of
// the controller and the command/status structs between controller and
// datapath.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BSQ_W    = 18;            // sum of four byte squares
  localparam int unsigned SUM_W    = 38;
  localparam int unsigned HALF_W   = SUM_W / 2;     // operand half for products
  localparam int unsigned PROD_W   = 2 * SUM_W;
  localparam int unsigned ROOT_W   = SUM_W;
  localparam int unsigned REM_W    = ROOT_W + 2;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned DVD_W    = SUM_W + FRAC_W;
  localparam int unsigned CORR_W   = FRAC_W + 1;

  localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CORR_W-1:0] ONE_Q16 = CORR_W'(1) << FRAC_W;

  // Controller step counts
  localparam int unsigned MUL_STEPS  = 5;           // four partial products + drain
  localparam int unsigned SQRT_STEPS = ROOT_W;      // one root bit per step
  localparam int unsigned DIV_STEPS  = DVD_W;       // one quotient bit per step
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  typedef struct packed {
    logic       acc_en;     // request accepted: add its words
    logic       mul_clr;    // clear the product register
    logic       mul_load;   // register one partial product
    logic       mul_add;    // add the registered partial product
    logic [1:0] mul_sel;    // which operand halves form the partial product
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       finish;     // register the result and clear the sums
  } bsc_cmd_t;

  typedef struct packed {
    logic prod_zero;        // plain or cipher sum is zero
  } bsc_status_t;

endpackage

// ===== rtl/bsc_datapath.sv =====
// ----------------------------------------------------------------------------
// bsc_datapath: sums, product, root and quotient engines
// Saturating byte-square accumulators, a 19x19 multiplier used over four
// steps, a two-bits-per-step square root and a one-bit-per-step divider.
// ----------------------------------------------------------------------------
module bsc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bsc_pkg::bsc_cmd_t             cmd_i,
  input  logic [bsc_pkg::WORD_W-1:0]    plain_word_i,
  input  logic [bsc_pkg::WORD_W-1:0]    cipher_word_i,
  input  logic                          plain_present_i,
  input  logic                          cipher_present_i,
  output bsc_pkg::bsc_status_t          status_o,
  output logic [bsc_pkg::CORR_W-1:0]    correlation_q16_o,
  output logic                          saturated_o
);
  import bsc_pkg::*;

  function automatic logic [BSQ_W-1:0] byte_sq_sum(input logic [WORD_W-1:0] w);
    logic [BSQ_W-1:0] t;
    logic [7:0]       b;
    t = '0;
    for (int k = 0; k < 4; k++) begin
      b = w[8*k +: 8];
      t = t + BSQ_W'(b) * BSQ_W'(b);
    end
    return t;
  endfunction

  // Returns {overflow, saturated sum}
  function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] acc,
                                             input logic [BSQ_W-1:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(v);
    if (s[SUM_W]) begin
      s = {1'b1, SUM_MAX};
    end
    return s;
  endfunction

  logic [SUM_W-1:0]  plain_sum_q, plain_sum_d;
  logic [SUM_W-1:0]  cipher_sum_q, cipher_sum_d;
  logic [SUM_W-1:0]  cross_sum_q, cross_sum_d;
  logic              ovf_q, ovf_d;
  logic [PROD_W-1:0] pp_q, pp_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [CORR_W-1:0] corr_q, corr_d;
  logic              sat_q, sat_d;

  logic [SUM_W:0]    p_add, c_add, x_add;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [SUM_W-1:0]  mul_p;
  logic [REM_W+1:0]  sqrt_t, sqrt_trial, sqrt_diff;
  logic              sqrt_ge;
  logic [REM_W-1:0]  div_t, div_diff;
  logic              div_ge;
  logic              prod_zero;

  assign prod_zero = (plain_sum_q == '0) || (cipher_sum_q == '0);
  assign status_o.prod_zero = prod_zero;

  always_comb begin
    p_add = sat_add(plain_sum_q, byte_sq_sum(plain_word_i));
    c_add = sat_add(cipher_sum_q, byte_sq_sum(cipher_word_i));
    x_add = sat_add(cross_sum_q, byte_sq_sum(plain_word_i & cipher_word_i));

    plain_sum_d  = plain_sum_q;
    cipher_sum_d = cipher_sum_q;
    cross_sum_d  = cross_sum_q;
    ovf_d        = ovf_q;
    priority if (cmd_i.finish) begin
      plain_sum_d  = '0;
      cipher_sum_d = '0;
      cross_sum_d  = '0;
      ovf_d        = 1'b0;
    end else if (cmd_i.acc_en) begin
      if (plain_present_i) begin
        plain_sum_d = p_add[SUM_W-1:0];
        ovf_d       = ovf_d | p_add[SUM_W];
      end
      if (cipher_present_i) begin
        cipher_sum_d = c_add[SUM_W-1:0];
        ovf_d        = ovf_d | c_add[SUM_W];
      end
      if (plain_present_i && cipher_present_i) begin
        cross_sum_d = x_add[SUM_W-1:0];
        ovf_d       = ovf_d | x_add[SUM_W];
      end
    end else begin
      // hold the sums
    end
  end

  // Partial product of one pair of operand halves, placed at its weight
  always_comb begin
    mul_a = cmd_i.mul_sel[1] ? plain_sum_q[SUM_W-1:HALF_W]  : plain_sum_q[HALF_W-1:0];
    mul_b = cmd_i.mul_sel[0] ? cipher_sum_q[SUM_W-1:HALF_W] : cipher_sum_q[HALF_W-1:0];
    mul_p = SUM_W'(mul_a) * SUM_W'(mul_b);
    pp_d  = pp_q;
    if (cmd_i.mul_load) begin
      unique case (cmd_i.mul_sel)
        2'b00:        pp_d = PROD_W'(mul_p);
        2'b01, 2'b10: pp_d = PROD_W'(mul_p) << HALF_W;
        default:      pp_d = PROD_W'(mul_p) << SUM_W;
      endcase
    end
  end

  // Root: bring down two radicand bits per step
  always_comb begin
    sqrt_t     = {rem_q, prod_q[PROD_W-1 -: 2]};
    sqrt_trial = {2'b00, root_q, 2'b01};
    sqrt_ge    = sqrt_t >= sqrt_trial;
    sqrt_diff  = sqrt_t - sqrt_trial;
  end

  // Quotient: bring down one dividend bit per step
  always_comb begin
    div_t    = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
    div_ge   = div_t >= REM_W'(root_q);
    div_diff = div_t - REM_W'(root_q);
  end

  always_comb begin
    prod_d = prod_q;
    if (cmd_i.mul_clr) begin
      prod_d = '0;
    end else if (cmd_i.mul_add) begin
      prod_d = prod_q + pp_q;
    end else if (cmd_i.sqrt_step) begin
      prod_d = prod_q << 2;
    end

    root_d = root_q;
    if (cmd_i.sqrt_init) begin
      root_d = '0;
    end else if (cmd_i.sqrt_step) begin
      root_d = {root_q[ROOT_W-2:0], sqrt_ge};
    end

    rem_d = rem_q;
    if (cmd_i.sqrt_init || cmd_i.div_init) begin
      rem_d = '0;
    end else if (cmd_i.sqrt_step) begin
      rem_d = sqrt_ge ? sqrt_diff[REM_W-1:0] : sqrt_t[REM_W-1:0];
    end else if (cmd_i.div_step) begin
      rem_d = div_ge ? div_diff : div_t;
    end

    dvd_d = dvd_q;
    if (cmd_i.div_init) begin
      dvd_d = {cross_sum_q, FRAC_W'(0)};
    end else if (cmd_i.div_step) begin
      dvd_d = {dvd_q[DVD_W-2:0], div_ge};
    end

    corr_d = corr_q;
    sat_d  = sat_q;
    if (cmd_i.finish) begin
      sat_d = ovf_q;
      if (prod_zero) begin
        corr_d = '0;
      end else if ((dvd_q[DVD_W-1:CORR_W] != '0) || (dvd_q[CORR_W-1:0] > ONE_Q16)) begin
        corr_d = ONE_Q16;
      end else begin
        corr_d = dvd_q[CORR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plain_sum_q  <= '0;
      cipher_sum_q <= '0;
      cross_sum_q  <= '0;
      ovf_q        <= 1'b0;
    end else begin
      plain_sum_q  <= plain_sum_d;
      cipher_sum_q <= cipher_sum_d;
      cross_sum_q  <= cross_sum_d;
      ovf_q        <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q   <= pp_d;
    prod_q <= prod_d;
    root_q <= root_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    corr_q <= corr_d;
    sat_q  <= sat_d;
  end

  assign correlation_q16_o = corr_q;
  assign saturated_o       = sat_q;

  a_clear_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (plain_sum_q == '0) && (cipher_sum_q == '0) &&
                     (cross_sum_q == '0) && !ovf_q)
    else $error("sums not cleared after result");

  a_div_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (root_q != '0))
    else $error("division by a zero root");

  a_sqrt_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sqrt_step |-> (rem_q <= {1'b0, root_q, 1'b0}))
    else $error("root remainder exceeds twice the root");

endmodule

// ===== rtl/bsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsc_ctrl: sequencer for the byte square correlation block
// Takes requests; on a final request steps the datapath through product, root
// and quotient, skipped when a sum is zero, and strobes the result.
// ----------------------------------------------------------------------------
module bsc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 last_i,
  input  bsc_pkg::bsc_status_t status_i,
  output bsc_pkg::bsc_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);
  import bsc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             accept;

  assign accept = start_i && !busy_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.acc_en  = accept;
    cmd_o.mul_sel = cnt_q[1:0];
    unique case (state_q)
      ST_MUL: begin
        cmd_o.mul_clr   = (cnt_q == '0);
        cmd_o.mul_load  = (cnt_q < CNT_W'(MUL_STEPS - 1));
        cmd_o.mul_add   = (cnt_q != '0);
        cmd_o.sqrt_init = (cnt_q == CNT_W'(MUL_STEPS - 1));
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cmd_o.div_init  = (cnt_q == CNT_W'(SQRT_STEPS - 1));
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && last_i) begin
            state_q <= ST_MUL;
            cnt_q   <= '0;
            busy_q  <= 1'b1;
          end
        end
        ST_MUL: begin
          if (status_i.prod_zero) begin
            state_q <= ST_EMIT;
          end else if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
            state_q <= ST_SQRT;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_SQRT: begin
          if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
            state_q <= ST_DIV;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_DIV: begin
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
            state_q <= ST_EMIT;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_EMIT: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  a_busy_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(start_i && last_i))
    else $error("busy raised without a final request");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("result strobed while still busy");

  a_busy_in_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> busy_q)
    else $error("not busy while computing");

endmodule

// ===== rtl/byte_square_correlation_top.sv =====
// ----------------------------------------------------------------------------
// byte_square_correlation_top: byte-square correlation of two word streams
// Accumulates byte squares of plaintext, ciphertext and their AND, and on
// the final request returns the correlation in unsigned Q1.16.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low. A request
// with last low is added to the sums at that edge and busy stays low, so such
// requests may follow one another every cycle. A request with last high adds
// its words and then raises busy while the 38x38 product is formed (four 19x19
// partial products through one registered multiplier), the square root runs
// at two radicand bits a cycle, the divider at one quotient bit a cycle, and
// a final step registers the result; when either sum is zero the root and
// division are skipped. The result shows on correlation_q16_o and saturated_o
// and is held until the next result, while done_o is high for exactly one
// cycle, in the same cycle in which busy drops; there is no back-pressure, so
// capture it then. All sums and the overflow flag behind saturated_o are
// cleared together with the result, ready for the next run.
module byte_square_correlation_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [bsc_pkg::WORD_W-1:0]    plain_word_i,
  input  logic [bsc_pkg::WORD_W-1:0]    cipher_word_i,
  input  logic                          plain_present_i,
  input  logic                          cipher_present_i,
  input  logic                          last_i,
  output logic                          done_o,
  output logic [bsc_pkg::CORR_W-1:0]    correlation_q16_o,
  output logic                          saturated_o
);
  import bsc_pkg::*;

  // Commands from the sequencer, status back from the datapath
  bsc_cmd_t    cmd;
  bsc_status_t status;

  bsc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .last_i   (last_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // Sums, product, root and divider; result registers hold until next run
  bsc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .plain_word_i      (plain_word_i),
    .cipher_word_i     (cipher_word_i),
    .plain_present_i   (plain_present_i),
    .cipher_present_i  (cipher_present_i),
    .status_o          (status),
    .correlation_q16_o (correlation_q16_o),
    .saturated_o       (saturated_o)
  );

endmodule
